### rtl/core/imu_tilt_roll_pitch_core_defines.svh
// Assertion macros shared by the tilt core RTL.
// Plain text macros only; no dependencies.
`ifndef IMU_TILT_ROLL_PITCH_CORE_DEFINES_SVH
`define IMU_TILT_ROLL_PITCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ITRP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ITRP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/itrp_pkg.sv
// Shared types, widths and constants of the tilt core.
// No dependencies; imported by every module of the core.
package itrp_pkg;

   // field widths
   localparam int AXIS_W     = 16;
   localparam int ROLL_W     = 17;
   localparam int PITCH_W    = 16;
   localparam int RATE_W     = 17;
   localparam int ANG_W      = 17;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_PACK_W = ROLL_W + PITCH_W + 2 * RATE_W;
   localparam int RSP_DATA_W = ((RSP_PACK_W + 7) / 8) * 8;

   // gyro rate: raw * 256 / 131, rounded, via reciprocal multiply
   localparam int GYRO_DIV    = 131;
   localparam int RATE_HALF   = (GYRO_DIV - 1) / 2;
   localparam int RATE_LIM    = 64035;
   localparam int RATE_FRAC   = 8;
   localparam int RATE_N_W    = AXIS_W + RATE_FRAC;
   localparam int RECIP_SHIFT = 32;
   localparam int RECIP_W     = 25;
   localparam logic [RECIP_W-1:0] GYRO_RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / GYRO_DIV);
   localparam int RATE_PROD_W = RATE_N_W + RECIP_W;
   localparam int RATE_Q_W    = RATE_PROD_W - RECIP_SHIFT;
   localparam int RATE_REM_W  = 9;
   localparam int RATE_LANES  = 2;

   // square root of (ay^2 + az^2) with FRAC_SHIFT fraction bits
   localparam int FRAC_SHIFT = 14;
   localparam int PROD_W     = 2 * AXIS_W - 1;
   localparam int SQ_W       = 2 * AXIS_W;
   localparam int N_W        = SQ_W + 2 * FRAC_SHIFT;
   localparam int ROOT_W     = N_W / 2;
   localparam int REM_W      = ROOT_W + 2;

   // vectoring CORDIC, angles in 2^-16 degree
   localparam int CORDIC_STAGES = 16;
   localparam int TAB_LEN       = 24;
   localparam int VW            = 34;
   localparam int ZW            = 26;
   localparam int ANG_DROP      = 8;
   localparam int RND_W         = ZW + 1 - ANG_DROP;
   localparam int ANG_HALF      = 128;
   localparam int LANES         = 2;
   localparam int LANE_ROLL     = 0;
   localparam int LANE_PITCH    = 1;
   localparam int ROLL_LIM      = 46080;
   localparam int PITCH_LIM     = 23040;

   localparam logic signed [ZW-1:0] ANG_90  = 26'sd5898240;
   localparam logic signed [ZW-1:0] ANG_180 = 26'sd11796480;

   localparam logic [ANG_W-1:0] ANG_LIM [LANES] = '{17'd46080, 17'd23040};

   // atan(2^-i) in 2^-16 degree
   localparam logic signed [ZW-1:0] ATAN_TAB [TAB_LEN] = '{
      26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
      26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
      26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
      26'sd917,     26'sd458,     26'sd229,    26'sd115,
      26'sd57,      26'sd29,      26'sd14,     26'sd7,
      26'sd4,       26'sd2,       26'sd1,      26'sd0
   };

   typedef struct packed {
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
      logic signed [AXIS_W-1:0] gyro_x_raw;
      logic signed [AXIS_W-1:0] gyro_y_raw;
   } sample_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
   } accel_type;

   typedef struct packed {
      logic signed [RATE_W-1:0] rate_x;
      logic signed [RATE_W-1:0] rate_y;
   } rates_type;

   typedef struct packed {
      accel_type accel;
      rates_type rates;
   } mid_type;

   typedef struct packed {
      accel_type          accel;
      rates_type          rates;
      logic [ROOT_W-1:0]  rad;
   } root_type;

   typedef struct packed {
      logic signed [ROLL_W-1:0]  roll_deg;
      logic signed [PITCH_W-1:0] pitch_deg;
      logic signed [RATE_W-1:0]  rate_x;
      logic signed [RATE_W-1:0]  rate_y;
   } result_type;

endpackage

### rtl/core/itrp_rate.sv
// Gyro rate scaling: raw * 256 / 131, rounded half away from zero.
// Four-stage reciprocal-multiply divider; uses itrp_pkg.
module itrp_rate
   import itrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_vld,
   input  sample_type in_data,
   output logic       out_vld,
   output mid_type    out_data
);

   localparam int DEPTH = 4;

   logic [DEPTH-1:0]          vld_ff;
   accel_type                 side_ff [DEPTH];
   logic signed [AXIS_W-1:0]  gyro [RATE_LANES];
   logic signed [RATE_W-1:0]  rate_ff [RATE_LANES];

   assign gyro[0] = in_data.gyro_x_raw;
   assign gyro[1] = in_data.gyro_y_raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0].accel_x <= in_data.accel_x;
         side_ff[0].accel_y <= in_data.accel_y;
         side_ff[0].accel_z <= in_data.accel_z;
         for (int i = 1; i < DEPTH; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   for (genvar l = 0; l < RATE_LANES; l++) begin : g_lane
      logic [AXIS_W-1:0]      mag;
      logic [RATE_N_W-1:0]    num_in;
      logic [RATE_N_W-1:0]    num0_ff, num1_ff;
      logic                   neg0_ff, neg1_ff, neg2_ff;
      logic [RATE_PROD_W-1:0] prod_in, prod_ff;
      logic [RATE_Q_W-1:0]    q;
      logic [RATE_N_W-1:0]    back;
      logic [RATE_N_W-1:0]    diff;
      logic [RATE_Q_W-1:0]    q_ff;
      logic [RATE_REM_W-1:0]  rem_ff;
      logic [RATE_Q_W-1:0]    qc;
      logic [RATE_Q_W-1:0]    qlim;

      // |raw| * 256 + 65: rounding folded into the dividend
      always_comb begin
         mag    = gyro[l][AXIS_W-1] ? -gyro[l] : gyro[l];
         num_in = {mag, {RATE_FRAC{1'b0}}} + RATE_N_W'(RATE_HALF);
      end

      assign prod_in = RATE_PROD_W'(num0_ff) * RATE_PROD_W'(GYRO_RECIP);

      // estimate is low by at most one; remainder decides the fix
      always_comb begin
         q    = prod_ff[RATE_PROD_W-1:RECIP_SHIFT];
         back = RATE_N_W'(q) * RATE_N_W'(GYRO_DIV);
         diff = num1_ff - back;
      end

      always_comb begin
         qc   = q_ff + {{(RATE_Q_W-1){1'b0}}, (rem_ff >= RATE_REM_W'(GYRO_DIV))};
         qlim = (qc > RATE_Q_W'(RATE_LIM)) ? RATE_Q_W'(RATE_LIM) : qc;
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            num0_ff    <= num_in;
            neg0_ff    <= gyro[l][AXIS_W-1];
            prod_ff    <= prod_in;
            num1_ff    <= num0_ff;
            neg1_ff    <= neg0_ff;
            q_ff       <= q;
            rem_ff     <= diff[RATE_REM_W-1:0];
            neg2_ff    <= neg1_ff;
            rate_ff[l] <= neg2_ff ? RATE_W'(-qlim) : RATE_W'(qlim);
         end
      end
   end

   assign out_vld              = vld_ff[DEPTH-1];
   assign out_data.accel       = side_ff[DEPTH-1];
   assign out_data.rates.rate_x = rate_ff[0];
   assign out_data.rates.rate_y = rate_ff[1];

endmodule

### rtl/core/itrp_sqrt.sv
// Pipelined integer square root of (ay^2 + az^2) * 2^28, one root bit per stage.
// Squares, sum and ROOT_W digit stages; uses itrp_pkg.
module itrp_sqrt
   import itrp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     adv,
   input  logic     in_vld,
   input  mid_type  in_data,
   output logic     out_vld,
   output root_type out_data
);

   localparam int DEPTH = ROOT_W + 2;

   logic [DEPTH-1:0]        vld_ff;
   mid_type                 side_ff [DEPTH];
   logic signed [SQ_W-1:0]  py, pz;
   logic [PROD_W-1:0]       sq_y_ff, sq_z_ff;
   logic [SQ_W-1:0]         sq_ff   [ROOT_W+1];
   logic [ROOT_W-1:0]       root_ff [ROOT_W+1];
   logic [REM_W-1:0]        rem_ff  [ROOT_W+1];

   assign py = in_data.accel.accel_y * in_data.accel.accel_y;
   assign pz = in_data.accel.accel_z * in_data.accel.accel_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= in_data;
         for (int i = 1; i < DEPTH; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
         sq_y_ff    <= py[PROD_W-1:0];
         sq_z_ff    <= pz[PROD_W-1:0];
         sq_ff[0]   <= SQ_W'(sq_y_ff) + SQ_W'(sq_z_ff);
         root_ff[0] <= '0;
         rem_ff[0]  <= '0;
      end
   end

   for (genvar r = 0; r < ROOT_W; r++) begin : g_digit
      logic [N_W-1:0]   nv;
      logic [REM_W+1:0] rem_sh;
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] diff;
      logic [REM_W-1:0] rem_in;
      logic [ROOT_W-1:0] root_in;

      always_comb begin
         nv     = {sq_ff[r], {(2 * FRAC_SHIFT){1'b0}}};
         rem_sh = {rem_ff[r], nv[N_W-1-2*r -: 2]};
         trial  = {2'b00, root_ff[r], 2'b01};
         diff   = rem_sh - trial;
         if (rem_sh >= trial) begin
            rem_in  = diff[REM_W-1:0];
            root_in = {root_ff[r][ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh[REM_W-1:0];
            root_in = {root_ff[r][ROOT_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_ff[r+1]   <= sq_ff[r];
            root_ff[r+1] <= root_in;
            rem_ff[r+1]  <= rem_in;
         end
      end
   end

   assign out_vld        = vld_ff[DEPTH-1];
   assign out_data.accel = side_ff[DEPTH-1].accel;
   assign out_data.rates = side_ff[DEPTH-1].rates;
   assign out_data.rad   = root_ff[ROOT_W];

endmodule

### rtl/core/itrp_cordic.sv
// Two-lane pipelined vectoring CORDIC: roll = atan2(ay, az), pitch = atan2(-ax, rad).
// Pre-rotation, CORDIC_STAGES micro-rotations, round and clamp; uses itrp_pkg.
module itrp_cordic
   import itrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       adv,
   input  logic       in_vld,
   input  root_type   in_data,
   output logic       out_vld,
   output result_type out_data
);

   localparam int DEPTH = CORDIC_STAGES + 2;

   logic [DEPTH-1:0]          vld_ff;
   rates_type                 rates_ff [DEPTH];
   logic signed [VW-1:0]      vx [LANES];
   logic signed [VW-1:0]      vy [LANES];
   logic signed [VW-1:0]      x_ff    [LANES][CORDIC_STAGES+1];
   logic signed [VW-1:0]      y_ff    [LANES][CORDIC_STAGES+1];
   logic signed [ZW-1:0]      z_ff    [LANES][CORDIC_STAGES+1];
   logic                      skip_ff [LANES][CORDIC_STAGES+1];
   logic signed [ANG_W-1:0]   ang_ff  [LANES];

   always_comb begin
      vx[LANE_ROLL]  = VW'(in_data.accel.accel_z) <<< FRAC_SHIFT;
      vy[LANE_ROLL]  = VW'(in_data.accel.accel_y) <<< FRAC_SHIFT;
      vx[LANE_PITCH] = signed'(VW'(in_data.rad));
      vy[LANE_PITCH] = -(VW'(in_data.accel.accel_x) <<< FRAC_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rates_ff[0] <= in_data.rates;
         for (int i = 1; i < DEPTH; i++) begin
            rates_ff[i] <= rates_ff[i-1];
         end
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic signed [VW-1:0] px, py;
      logic signed [ZW-1:0] pz;
      logic                 pskip;
      logic signed [ZW-1:0] zf;
      logic [ZW-1:0]        mag;
      logic [ZW:0]          sum;
      logic [RND_W-1:0]     rnd;
      logic [ANG_W-1:0]     rlim;

      // axis cases are exact and bypass the rotations; x < 0 turns by 180 deg
      always_comb begin
         px    = vx[l];
         py    = vy[l];
         pz    = '0;
         pskip = 1'b0;
         priority if (vy[l] == '0) begin
            pskip = 1'b1;
            pz    = vx[l][VW-1] ? ANG_180 : '0;
         end else if (vx[l] == '0) begin
            pskip = 1'b1;
            pz    = vy[l][VW-1] ? -ANG_90 : ANG_90;
         end else if (vx[l][VW-1]) begin
            pz = vy[l][VW-1] ? -ANG_180 : ANG_180;
            px = -vx[l];
            py = -vy[l];
         end else begin
            pz = '0;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            x_ff[l][0]    <= px;
            y_ff[l][0]    <= py;
            z_ff[l][0]    <= pz;
            skip_ff[l][0] <= pskip;
         end
      end

      for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
         logic signed [VW-1:0] x_in, y_in;
         logic signed [ZW-1:0] z_in;

         always_comb begin
            x_in = x_ff[l][s];
            y_in = y_ff[l][s];
            z_in = z_ff[l][s];
            if (!skip_ff[l][s]) begin
               if (!y_ff[l][s][VW-1]) begin
                  x_in = x_ff[l][s] + (y_ff[l][s] >>> s);
                  y_in = y_ff[l][s] - (x_ff[l][s] >>> s);
                  z_in = z_ff[l][s] + ATAN_TAB[s];
               end else begin
                  x_in = x_ff[l][s] - (y_ff[l][s] >>> s);
                  y_in = y_ff[l][s] + (x_ff[l][s] >>> s);
                  z_in = z_ff[l][s] - ATAN_TAB[s];
               end
            end
         end

         always_ff @(posedge clock) begin
            if (adv) begin
               x_ff[l][s+1]    <= x_in;
               y_ff[l][s+1]    <= y_in;
               z_ff[l][s+1]    <= z_in;
               skip_ff[l][s+1] <= skip_ff[l][s];
            end
         end
      end

      // 2^-16 deg to 2^-8 deg, half away from zero, then clamp
      always_comb begin
         zf   = z_ff[l][CORDIC_STAGES];
         mag  = zf[ZW-1] ? ZW'(-zf) : ZW'(zf);
         sum  = {1'b0, mag} + (ZW+1)'(ANG_HALF);
         rnd  = sum[ZW:ANG_DROP];
         rlim = (rnd > RND_W'(ANG_LIM[l])) ? ANG_LIM[l] : rnd[ANG_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ang_ff[l] <= zf[ZW-1] ? ANG_W'(-rlim) : ANG_W'(rlim);
         end
      end
   end

   assign out_vld            = vld_ff[DEPTH-1];
   assign out_data.roll_deg  = ang_ff[LANE_ROLL];
   assign out_data.pitch_deg = ang_ff[LANE_PITCH][PITCH_W-1:0];
   assign out_data.rate_x    = rates_ff[DEPTH-1].rate_x;
   assign out_data.rate_y    = rates_ff[DEPTH-1].rate_y;

endmodule

### rtl/core/imu_tilt_roll_pitch_core.sv
// Tilt and gyro rate core: roll = atan2(ay, az) and pitch = atan2(-ax, sqrt(ay^2+az^2))
// in 1/256 degree, and both gyro axes scaled by 1/131 in 1/256 deg/s, rounded. The
// block takes one sample beat per clock while req_tready is high and returns one result
// beat per sample, in order. An accepted sample passes through the gyro divider, the
// square root (squares, sum and one root bit per stage over 30 stages), the CORDIC with
// its pre-rotation and rounding, and then the output register. A skid register behind
// the output keeps req_tready a registered signal; the whole pipeline holds while the
// skid is full.
// Depends on itrp_pkg, itrp_rate, itrp_sqrt, itrp_cordic and the assertion macros.
`include "imu_tilt_roll_pitch_core_defines.svh"

module imu_tilt_roll_pitch_core
   import itrp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // accel_x, accel_y, accel_z, gyro_x_raw, gyro_y_raw (16 bits each)
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // roll_deg (17), pitch_deg (16), rate_x (17), rate_y (17), zero pad (5)
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   sample_type in_d;
   logic       adv;
   logic       mid_vld, root_vld, pipe_vld;
   mid_type    mid_d;
   root_type   root_d;
   result_type pipe_d;

   logic       rsp_vld_ff, rsp_vld_in;
   result_type rsp_ff, rsp_in;
   logic       skid_vld_ff, skid_vld_in;
   result_type skid_ff, skid_in;

   assign in_d.accel_x    = req_tdata[0*AXIS_W +: AXIS_W];
   assign in_d.accel_y    = req_tdata[1*AXIS_W +: AXIS_W];
   assign in_d.accel_z    = req_tdata[2*AXIS_W +: AXIS_W];
   assign in_d.gyro_x_raw = req_tdata[3*AXIS_W +: AXIS_W];
   assign in_d.gyro_y_raw = req_tdata[4*AXIS_W +: AXIS_W];

   assign adv        = !skid_vld_ff;
   assign req_tready = adv;

   itrp_rate u_rate (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (req_tvalid),
      .in_data  (in_d),
      .out_vld  (mid_vld),
      .out_data (mid_d)
   );

   itrp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (mid_vld),
      .in_data  (mid_d),
      .out_vld  (root_vld),
      .out_data (root_d)
   );

   itrp_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_vld   (root_vld),
      .in_data  (root_d),
      .out_vld  (pipe_vld),
      .out_data (pipe_d)
   );

   // skid beat goes out first; else pipeline beat to output, or to skid if output held
   always_comb begin
      rsp_vld_in  = rsp_vld_ff;
      rsp_in      = rsp_ff;
      skid_vld_in = skid_vld_ff;
      skid_in     = skid_ff;
      priority if (!rsp_vld_ff || rsp_tready) begin
         if (skid_vld_ff) begin
            rsp_vld_in  = 1'b1;
            rsp_in      = skid_ff;
            skid_vld_in = 1'b0;
         end else begin
            rsp_vld_in = pipe_vld;
            rsp_in     = pipe_d;
         end
      end else if (pipe_vld && adv) begin
         skid_vld_in = 1'b1;
         skid_in     = pipe_d;
      end else begin
         skid_vld_in = skid_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff  <= rsp_vld_in;
         skid_vld_ff <= skid_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {(RSP_DATA_W - RSP_PACK_W)'(0), rsp_ff.rate_y, rsp_ff.rate_x,
                        rsp_ff.pitch_deg, rsp_ff.roll_deg};

   `ITRP_ASSERT_IMP(a_skid_behind_rsp, clock, reset, skid_vld_ff, rsp_vld_ff, "skid full with empty output")
   `ITRP_ASSERT_NXT(a_skid_catches, clock, reset, rsp_vld_ff && !rsp_tready && pipe_vld && !skid_vld_ff, skid_vld_ff, "held output dropped a pipeline beat")
   `ITRP_ASSERT_NXT(a_skid_drains, clock, reset, skid_vld_ff && rsp_tready, rsp_vld_ff && !skid_vld_ff, "skid beat not moved to output")
   `ITRP_ASSERT_IMP(a_pitch_range, clock, reset, rsp_vld_ff, (rsp_ff.pitch_deg <= PITCH_LIM) && (rsp_ff.pitch_deg >= -PITCH_LIM), "pitch out of range")

endmodule
